// ===== sv/lpr_pkg.sv =====
package lpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 20;
  localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = SLOT_W;
  localparam int FAULT_W   = 32;
  localparam int CFG_W     = 4;

  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(8);
  localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(FRAMES - 1);

  // Command queue between the front and back ends
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic OP_REF   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [FAULT_W-1:0]   fault_t;

  typedef enum logic {
    CMD_REF   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    page_t     page;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_MATCH = 2'b01,
    ST_UPD   = 2'b10
  } back_state_t;

endpackage

// ===== sv/lpr_front.sv =====
module lpr_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  lpr_pkg::page_t   in_page,
  input  lpr_pkg::q_stat_t q_stat,
  output logic             push,
  output lpr_pkg::cmd_t    push_cmd
);

  lpr_pkg::cmd_kind_t kind;

  always_comb begin
    unique case (in_op)
      lpr_pkg::OP_REF:   kind = lpr_pkg::CMD_REF;
      lpr_pkg::OP_CLEAR: kind = lpr_pkg::CMD_CLEAR;
      default:           kind = lpr_pkg::CMD_REF;
    endcase
  end

  assign in_ready      = !q_stat.full;
  assign push          = in_valid && in_ready;
  assign push_cmd.kind = kind;
  // The page is meaningless for a clear, so it is dropped there.
  assign push_cmd.page = (kind == lpr_pkg::CMD_CLEAR) ? '0 : in_page;

endmodule

// ===== sv/lpr_queue.sv =====
module lpr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lpr_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output lpr_pkg::cmd_t    head,
  output lpr_pkg::q_stat_t stat
);

  lpr_pkg::cmd_t                entries_r [lpr_pkg::QDEPTH];
  logic [lpr_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [lpr_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [lpr_pkg::QCNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == lpr_pkg::QPTR_W'(lpr_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == lpr_pkg::QPTR_W'(lpr_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head       = entries_r[rd_ptr_r];
  assign stat.full  = (count_r == lpr_pkg::QCNT_W'(lpr_pkg::QDEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// ===== sv/lpr_back.sv =====
module lpr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lpr_pkg::CFG_W-1:0]  frames_in_use,
  input  lpr_pkg::q_stat_t           q_stat,
  input  lpr_pkg::cmd_t              head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output lpr_pkg::slot_t             out_slot,
  output logic                       out_evicted_valid,
  output lpr_pkg::page_t             out_evicted_page,
  output lpr_pkg::fault_t            out_fault_count
);

  lpr_pkg::back_state_t         state_r, state_nxt;

  logic [lpr_pkg::FRAMES-1:0]   valid_r, valid_nxt;
  lpr_pkg::page_t               page_r    [lpr_pkg::FRAMES];
  lpr_pkg::rank_t               rank_r    [lpr_pkg::FRAMES];
  lpr_pkg::rank_t               rank_nxt  [lpr_pkg::FRAMES];
  lpr_pkg::fault_t              faults_r, faults_nxt;

  // Classification held between the compare and update cycles
  logic                         clr_r;
  logic                         hit_r;
  logic                         fill_r;
  lpr_pkg::slot_t               slot_r;
  lpr_pkg::page_t               page_new_r;

  logic                         out_valid_r;
  logic                         out_hit_r;
  lpr_pkg::slot_t               out_slot_r;
  logic                         out_evicted_valid_r;
  lpr_pkg::page_t               out_evicted_page_r;
  lpr_pkg::fault_t              out_fault_count_r;

  logic [lpr_pkg::FRAMES-1:0]   active;
  logic [lpr_pkg::FRAMES-1:0]   match;
  logic [lpr_pkg::FRAMES-1:0]   empty;
  lpr_pkg::slot_t               hit_slot;
  lpr_pkg::slot_t               empty_slot;
  lpr_pkg::slot_t               victim;
  lpr_pkg::rank_t               best;
  lpr_pkg::rank_t               old_rank;
  logic                         upd_go;

  // A count of zero behaves as one frame; frame 0 therefore always takes part.
  always_comb begin
    for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
      active[i] = (i == 0) || (i < int'(frames_in_use));
      match[i]  = active[i] && valid_r[i] && (page_r[i] == head.page);
      empty[i]  = active[i] && !valid_r[i];
    end
  end

  always_comb begin
    hit_slot   = '0;
    empty_slot = '0;
    for (int i = lpr_pkg::FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = lpr_pkg::SLOT_W'(i);
      end
      if (empty[i]) begin
        empty_slot = lpr_pkg::SLOT_W'(i);
      end
    end
  end

  // Oldest active frame; a strict compare lets the lowest index win a tie.
  always_comb begin
    best   = '0;
    victim = '0;
    for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
      if (active[i] && (rank_r[i] > best)) begin
        best   = rank_r[i];
        victim = lpr_pkg::SLOT_W'(i);
      end
    end
  end

  assign pop    = (state_r == lpr_pkg::ST_MATCH) && !q_stat.empty;
  assign upd_go = (state_r == lpr_pkg::ST_UPD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpr_pkg::ST_MATCH: begin
        if (pop) begin
          state_nxt = lpr_pkg::ST_UPD;
        end
      end
      lpr_pkg::ST_UPD: begin
        if (upd_go) begin
          state_nxt = lpr_pkg::ST_MATCH;
        end
      end
      default: state_nxt = lpr_pkg::ST_MATCH;
    endcase
  end

  assign old_rank = rank_r[slot_r];

  // Frames newer than the one used age by one; a fill ages every valid active frame.
  always_comb begin
    valid_nxt  = valid_r;
    faults_nxt = faults_r;
    for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (upd_go) begin
      if (clr_r) begin
        valid_nxt  = '0;
        faults_nxt = '0;
        for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
          rank_nxt[i] = '0;
        end
      end else begin
        for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
          if ((lpr_pkg::SLOT_W'(i) != slot_r) && valid_r[i] && active[i] &&
              (fill_r || (rank_r[i] < old_rank)) &&
              (rank_r[i] != lpr_pkg::RANK_MAX)) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        rank_nxt[slot_r] = '0;
        if (!hit_r) begin
          valid_nxt[slot_r] = 1'b1;
          if (faults_r != '1) begin
            faults_nxt = faults_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpr_pkg::ST_MATCH;
      valid_r     <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      faults_r <= faults_nxt;
      for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      clr_r      <= (head.kind == lpr_pkg::CMD_CLEAR);
      hit_r      <= |match;
      // A fill is a miss that finds an empty frame; a hit is never a fill.
      fill_r     <= !(|match) && (|empty);
      page_new_r <= head.page;
      if (|match) begin
        slot_r <= hit_slot;
      end else if (|empty) begin
        slot_r <= empty_slot;
      end else begin
        slot_r <= victim;
      end
    end
    if (upd_go) begin
      out_fault_count_r <= faults_nxt;
      if (clr_r) begin
        out_hit_r           <= 1'b0;
        out_slot_r          <= '0;
        out_evicted_valid_r <= 1'b0;
        out_evicted_page_r  <= '0;
      end else begin
        out_hit_r           <= hit_r;
        out_slot_r          <= slot_r;
        out_evicted_valid_r <= !hit_r && !fill_r;
        out_evicted_page_r  <= (!hit_r && !fill_r) ? page_r[slot_r] : '0;
        if (!hit_r) begin
          page_r[slot_r] <= page_new_r;
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_count   = out_fault_count_r;

endmodule

// ===== sv/lru_page_replacement.sv =====
// LRU page table over up to eight fully associative frames. Every input transfer
// (a page reference, or a clear of all frames and of the fault count) yields exactly
// one result transfer: hit flag, frame used, any evicted page and the running,
// saturating fault count. The front end takes items into a two-entry command queue;
// the back end first compares the page against every active frame and chooses the
// victim, then updates the recency ranks and registers the result, and pops no
// new item before that update. An item passes the queue entry, the classification
// registers and the result register in turn. The back end waits only while its
// result register is still held by the consumer. frames_in_use is to be written
// through the cfg port only while no item is in flight; the block does not enforce
// this. Zero behaves as one frame and values above eight as eight.
module lru_page_replacement (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  lpr_pkg::page_t             in_page,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output lpr_pkg::slot_t             out_slot,
  output logic                       out_evicted_valid,
  output lpr_pkg::page_t             out_evicted_page,
  output lpr_pkg::fault_t            out_fault_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lpr_pkg::CFG_W-1:0]  cfg_frames_in_use
);

  logic [lpr_pkg::CFG_W-1:0] frames_in_use_r;
  logic                      push;
  logic                      pop;
  lpr_pkg::cmd_t             push_cmd;
  lpr_pkg::cmd_t             head;
  lpr_pkg::q_stat_t          q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= lpr_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use_r <= cfg_frames_in_use;
    end
  end

  lpr_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_page  (in_page),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  lpr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .frames_in_use     (frames_in_use_r),
    .q_stat            (q_stat),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

endmodule

// ===== sv/lpr_checker.sv =====
module lpr_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_hit,
  input  lpr_pkg::slot_t             out_slot,
  input  logic                       out_evicted_valid,
  input  lpr_pkg::page_t             out_evicted_page,
  input  lpr_pkg::fault_t            out_fault_count
);

  // A result held back by the consumer must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_hit) && $stable(out_slot) &&
      $stable(out_evicted_valid) && $stable(out_evicted_page) &&
      $stable(out_fault_count))
    else $error("result changed while stalled");

  // A hit never evicts anything.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid && (out_evicted_page == '0))
    else $error("eviction reported on a hit");

  // Without an eviction the evicted page reads as zero.
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> (out_evicted_page == '0))
    else $error("evicted page set without eviction");

  // With no fault since the last clear nothing can be resident yet.
  a_no_fault_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fault_count == '0) |-> !out_hit && !out_evicted_valid)
    else $error("hit or eviction with zero fault count");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);
